/* rtl/ntcs_pkg.sv */
// shared types and constants of the ntc beta temperature smoother
package ntcs_pkg;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DIVIDER_RATIO   = 4'd0,
        REG_BETA_VALUE      = 4'd1,
        REG_ADC_LOW_LIMIT   = 4'd2,
        REG_ADC_HIGH_LIMIT  = 4'd3,
        REG_TEMP_LOW_LIMIT  = 4'd4,
        REG_TEMP_HIGH_LIMIT = 4'd5,
        REG_OFFSET_ONE      = 4'd6,
        REG_OFFSET_TWO      = 4'd7
    } cfg_reg_t;

    typedef logic [11:0]        sample_t;
    typedef logic signed [15:0] temp_t;

    localparam int ADC_FULL    = 4095;
    localparam int KELVIN_HUND = 27315;
    localparam int T0_HUND     = 29815;
    localparam int LN2_SCALED  = 52905;
    localparam int RAW_CLIP    = 40000;
    localparam int TEMP_MIN    = -10000;
    localparam int TEMP_MAX    = 20000;
    localparam int LOG_FRAC_W  = 16;
    localparam int RATIO_FRAC  = 12;
    localparam int BETA_Q_W    = 17;
    localparam int BETA_SHIFT  = 24;

endpackage

/* rtl/ntcs_stream_if.sv */
// valid/ready channel interfaces for samples and results
interface ntcs_in_if;
    logic              valid;
    logic              ready;
    ntcs_pkg::sample_t sample_one;
    ntcs_pkg::sample_t sample_two;

    modport source (output valid, output sample_one, output sample_two, input ready);
    modport sink   (input valid, input sample_one, input sample_two, output ready);
endinterface

interface ntcs_out_if;
    logic            valid;
    logic            ready;
    ntcs_pkg::temp_t smooth_one;
    ntcs_pkg::temp_t smooth_two;
    logic            fault_one;
    logic            fault_two;
    logic [15:0]     error_total;

    modport source (output valid, output smooth_one, output smooth_two, output fault_one,
                    output fault_two, output error_total, input ready);
    modport sink   (input valid, input smooth_one, input smooth_two, input fault_one,
                    input fault_two, input error_total, output ready);
endinterface

/* rtl/ntcs_ram.sv */
// generic single write port ram with registered read
module ntcs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/ntc_beta_temperature_smoother_top.sv */
// top level of the two channel ntc beta temperature smoother
// Two NTC channels are oversampled, converted with the Beta equation and smoothed.
// An item that does not close a burst is only added to the sums. The item that closes a
// burst of OVERSAMPLE items starts one shared sequencer: per channel three base-2
// logarithms (a normalize step, then squarings on a 31x31 multiplier for 16 fraction bits),
// a scaling step and a restoring divide for a 17 bit quotient, then a ram read-modify-write
// of the window entry and one restoring divide for a TOT_W = 17 + clog2(WINDOW) bit quotient
// per channel for the windowed mean. The next item is taken once the result sits in the
// output register, which holds it until the sink takes it. The window values live in
// one ram of WINDOW entries holding both channels; no clearing pass is needed since
// an old entry is used only after it has been written.
module ntc_beta_temperature_smoother_top #(
    parameter int OVERSAMPLE = 16,
    parameter int WINDOW     = 10
) (
    input  logic                             clk,
    input  logic                             rst_n,
    ntcs_in_if.sink                          in_ch,
    ntcs_out_if.source                       out_ch,
    input  logic                             cfg_we,
    input  logic [ntcs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ntcs_pkg::CFG_DATA_W-1:0]  cfg_data
);

    // widths that follow from the parameters
    localparam int SUM_W  = $clog2(ntcs_pkg::ADC_FULL * OVERSAMPLE + 1);
    localparam int LOG_W  = (SUM_W > 16) ? SUM_W : 16;
    localparam int BC_W   = (OVERSAMPLE > 1) ? $clog2(OVERSAMPLE) : 1;
    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int TOT_W  = 17 + $clog2(WINDOW);
    localparam int LOW_W  = (TOT_W > ntcs_pkg::BETA_Q_W) ? TOT_W : ntcs_pkg::BETA_Q_W;
    localparam int ITER_W = $clog2(LOW_W + 1);

    localparam logic [SUM_W-1:0] OS_SUM   = SUM_W'(OVERSAMPLE);
    localparam logic [SUM_W-1:0] FULL_SUM = SUM_W'(ntcs_pkg::ADC_FULL * OVERSAMPLE);
    localparam logic [BC_W-1:0]  BC_LAST  = BC_W'(OVERSAMPLE - 1);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_SETUP, S_LOG_NORM, S_LOG_SQR, S_LOG_ACC, S_MUL, S_DSUM, S_NCHK,
        S_DIV, S_BFIN, S_RESULT, S_WREAD, S_WUPD, S_WLOAD, S_WFIN, S_OUT
    } state_t;

    typedef enum logic [1:0] {LOG_RATIO, LOG_NUM, LOG_SUM} log_sel_t;

    // configuration registers
    logic [15:0]        ratio_reg;
    logic [13:0]        beta_reg;
    logic [11:0]        adc_lo_reg;
    logic [11:0]        adc_hi_reg;
    logic signed [15:0] t_lo_reg;
    logic signed [15:0] t_hi_reg;
    logic signed [10:0] off1_reg;
    logic signed [10:0] off2_reg;

    // sequencer state
    state_t             state_reg;
    log_sel_t           log_sel_reg;
    logic               ch_reg;
    logic [SUM_W-1:0]   sum1_reg, sum2_reg;
    logic [BC_W-1:0]    bcount_reg;
    logic [SUM_W-1:0]   s1_reg, s2_reg;
    logic [SUM_W-1:0]   cur_s_reg, num_reg;
    logic               sat_reg;
    logic [30:0]        m_reg;
    logic [4:0]         e_reg;
    logic [15:0]        frac_reg;
    logic [3:0]         sq_cnt_reg;
    logic signed [23:0] l2_reg;
    logic signed [40:0] dprod_reg;
    logic [28:0]        nprod_reg;
    logic [40:0]        d_reg;
    logic [40:0]        div_rem_reg;
    logic [LOW_W-1:0]   div_low_reg;
    logic [LOW_W-1:0]   div_q_reg;
    logic [ITER_W-1:0]  div_cnt_reg;
    logic               div_win_reg;
    logic               neg_reg;
    logic signed [16:0] raw_reg;
    ntcs_pkg::temp_t    v1_reg, v2_reg, sm1_reg, sm2_reg;
    logic               f1_reg, f2_reg;
    logic [15:0]        fault_cnt_reg;
    logic signed [TOT_W-1:0] tot1_reg, tot2_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic               full_reg;

    // output register
    logic               out_valid_reg;
    ntcs_pkg::temp_t    out_sm1_reg, out_sm2_reg;
    logic               out_f1_reg, out_f2_reg;
    logic [15:0]        out_err_reg;

    // window ram
    logic               ram_we;
    logic [31:0]        ram_rdata;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ratio_reg  <= 16'd4096;
            beta_reg   <= 14'd3950;
            adc_lo_reg <= 12'd10;
            adc_hi_reg <= 12'd4085;
            t_lo_reg   <= -16'sd1000;
            t_hi_reg   <= 16'sd10000;
            off1_reg   <= '0;
            off2_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (ntcs_pkg::cfg_reg_t'(cfg_index))
                ntcs_pkg::REG_DIVIDER_RATIO:   ratio_reg  <= cfg_data;
                ntcs_pkg::REG_BETA_VALUE:      beta_reg   <= cfg_data[13:0];
                ntcs_pkg::REG_ADC_LOW_LIMIT:   adc_lo_reg <= cfg_data[11:0];
                ntcs_pkg::REG_ADC_HIGH_LIMIT:  adc_hi_reg <= cfg_data[11:0];
                ntcs_pkg::REG_TEMP_LOW_LIMIT:  t_lo_reg   <= cfg_data;
                ntcs_pkg::REG_TEMP_HIGH_LIMIT: t_hi_reg   <= cfg_data;
                ntcs_pkg::REG_OFFSET_ONE:      off1_reg   <= cfg_data[10:0];
                ntcs_pkg::REG_OFFSET_TWO:      off2_reg   <= cfg_data[10:0];
                default: ;
            endcase
        end
    end

    // burst setup for the channel under conversion
    logic [SUM_W-1:0] setup_s, setup_seff, setup_num;
    logic             setup_sat;

    always_comb
    begin
        setup_s    = ch_reg ? s2_reg : s1_reg;
        setup_sat  = (setup_s <= SUM_W'(adc_lo_reg) * OS_SUM)
                  || (setup_s >= SUM_W'(adc_hi_reg) * OS_SUM);
        setup_seff = (setup_s == '0) ? OS_SUM : setup_s;
        setup_num  = (setup_seff >= FULL_SUM) ? '0 : FULL_SUM - setup_seff;
    end

    // log2 operand select and normalization by leading one
    logic [LOG_W-1:0] log_x;
    logic [4:0]       e_calc;
    logic [30:0]      m_init;

    always_comb
    begin
        case (log_sel_reg)
            LOG_RATIO: log_x = LOG_W'(ratio_reg);
            LOG_NUM:   log_x = LOG_W'(num_reg);
            default:   log_x = LOG_W'(cur_s_reg);
        endcase
        e_calc = '0;
        for (int i = 0; i < LOG_W; i++)
        begin
            if (log_x[i])
            begin
                e_calc = 5'(i);
            end
        end
        m_init = 31'(log_x) << (5'd30 - e_calc);
    end

    // one squaring step of the mantissa in q30
    logic [61:0] sq_prod;
    logic [31:0] msq;
    logic signed [23:0] log_val;

    assign sq_prod = m_reg * m_reg;
    assign msq     = sq_prod[61:30];
    assign log_val = $signed({3'b000, e_reg, frac_reg});

    // beta equation denominators and numerator
    logic signed [16:0] ln2_k;
    logic signed [40:0] dprod_calc;
    logic signed [41:0] d_sum;
    logic [53:0]        n_full;
    logic               n_ovf;

    assign ln2_k      = 17'(ntcs_pkg::LN2_SCALED);
    assign dprod_calc = l2_reg * ln2_k;
    assign d_sum      = $signed({4'b0000, beta_reg, 24'd0}) + 42'(dprod_reg);
    assign n_full     = {1'b0, nprod_reg, 24'd0} + 54'(d_reg >> 1);
    assign n_ovf      = {4'b0000, n_full[53:17]} >= d_reg;

    // restoring divider step
    logic [41:0] rem_sh, rem_diff;
    logic        rem_ge;

    assign rem_sh   = {div_rem_reg, div_low_reg[LOW_W-1]};
    assign rem_diff = rem_sh - {1'b0, d_reg};
    assign rem_ge   = rem_sh >= {1'b0, d_reg};

    // temperature from quotient, fault check and offset
    logic signed [18:0] bfin_t;
    logic signed [15:0] clamp_t;
    ntcs_pkg::temp_t    fin_v;
    logic               fin_fault;

    always_comb
    begin
        bfin_t = $signed({2'b00, div_q_reg[ntcs_pkg::BETA_Q_W-1:0]})
               - 19'(ntcs_pkg::KELVIN_HUND);
        fin_fault = sat_reg || (raw_reg < 17'(t_lo_reg)) || (raw_reg > 17'(t_hi_reg));
        if (raw_reg < 17'(ntcs_pkg::TEMP_MIN))
        begin
            clamp_t = 16'(ntcs_pkg::TEMP_MIN);
        end
        else if (raw_reg > 17'(ntcs_pkg::TEMP_MAX))
        begin
            clamp_t = 16'(ntcs_pkg::TEMP_MAX);
        end
        else
        begin
            clamp_t = raw_reg[15:0];
        end
        fin_v = clamp_t + 16'(ch_reg ? off2_reg : off1_reg);
    end

    // window totals and mean divide setup
    logic signed [15:0]      old1, old2;
    logic signed [TOT_W-1:0] tot1_n, tot2_n, win_a;
    logic [TOT_W-1:0]        win_mag, win_dvd;
    logic [CNT_W-1:0]        win_cnt;
    logic [TOT_W-1:0]        win_r, win_res;

    always_comb
    begin
        old1    = ram_rdata[15:0];
        old2    = ram_rdata[31:16];
        tot1_n  = tot1_reg + TOT_W'(v1_reg) - (full_reg ? TOT_W'(old1) : '0);
        tot2_n  = tot2_reg + TOT_W'(v2_reg) - (full_reg ? TOT_W'(old2) : '0);
        win_cnt = full_reg ? CNT_W'(WINDOW) : CNT_W'(slot_reg) + 1'b1;
        win_a   = ch_reg ? tot2_reg : tot1_reg;
        win_mag = win_a[TOT_W-1] ? TOT_W'(-win_a) : TOT_W'(win_a);
        win_dvd = win_mag + TOT_W'(win_cnt >> 1);
        win_r   = div_q_reg[TOT_W-1:0];
        win_res = neg_reg ? -win_r : win_r;
    end

    assign ram_we = (state_reg == S_WUPD);

    ntcs_ram #(
        .WIDTH (32),
        .DEPTH (WINDOW)
    ) u_window_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_reg),
        .wdata ({v2_reg, v1_reg}),
        .raddr (slot_reg),
        .rdata (ram_rdata)
    );

    // sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            log_sel_reg   <= LOG_RATIO;
            ch_reg        <= 1'b0;
            sum1_reg      <= '0;
            sum2_reg      <= '0;
            bcount_reg    <= '0;
            s1_reg        <= '0;
            s2_reg        <= '0;
            cur_s_reg     <= '0;
            num_reg       <= '0;
            sat_reg       <= 1'b0;
            m_reg         <= '0;
            e_reg         <= '0;
            frac_reg      <= '0;
            sq_cnt_reg    <= '0;
            l2_reg        <= '0;
            dprod_reg     <= '0;
            nprod_reg     <= '0;
            d_reg         <= '0;
            div_rem_reg   <= '0;
            div_low_reg   <= '0;
            div_q_reg     <= '0;
            div_cnt_reg   <= '0;
            div_win_reg   <= 1'b0;
            neg_reg       <= 1'b0;
            raw_reg       <= '0;
            v1_reg        <= '0;
            v2_reg        <= '0;
            sm1_reg       <= '0;
            sm2_reg       <= '0;
            f1_reg        <= 1'b0;
            f2_reg        <= 1'b0;
            fault_cnt_reg <= '0;
            tot1_reg      <= '0;
            tot2_reg      <= '0;
            slot_reg      <= '0;
            full_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_sm1_reg   <= '0;
            out_sm2_reg   <= '0;
            out_f1_reg    <= 1'b0;
            out_f2_reg    <= 1'b0;
            out_err_reg   <= '0;
        end
        else
        begin
            // result transfer frees the output register
            if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_ch.valid)
                    begin
                        if (bcount_reg == BC_LAST)
                        begin
                            s1_reg     <= sum1_reg + SUM_W'(in_ch.sample_one);
                            s2_reg     <= sum2_reg + SUM_W'(in_ch.sample_two);
                            sum1_reg   <= '0;
                            sum2_reg   <= '0;
                            bcount_reg <= '0;
                            ch_reg     <= 1'b0;
                            state_reg  <= S_SETUP;
                        end
                        else
                        begin
                            sum1_reg   <= sum1_reg + SUM_W'(in_ch.sample_one);
                            sum2_reg   <= sum2_reg + SUM_W'(in_ch.sample_two);
                            bcount_reg <= bcount_reg + 1'b1;
                        end
                    end
                end

                S_SETUP:
                begin
                    sat_reg     <= setup_sat;
                    cur_s_reg   <= setup_seff;
                    num_reg     <= setup_num;
                    l2_reg      <= -24'(ntcs_pkg::RATIO_FRAC << ntcs_pkg::LOG_FRAC_W);
                    log_sel_reg <= LOG_RATIO;
                    if (setup_num == '0 || ratio_reg == '0)
                    begin
                        // zero resistance: the reading sits at absolute zero
                        raw_reg   <= -17'(ntcs_pkg::KELVIN_HUND);
                        state_reg <= S_RESULT;
                    end
                    else
                    begin
                        state_reg <= S_LOG_NORM;
                    end
                end

                S_LOG_NORM:
                begin
                    m_reg      <= m_init;
                    e_reg      <= e_calc;
                    frac_reg   <= '0;
                    sq_cnt_reg <= '0;
                    state_reg  <= S_LOG_SQR;
                end

                S_LOG_SQR:
                begin
                    frac_reg   <= {frac_reg[14:0], msq[31]};
                    m_reg      <= msq[31] ? msq[31:1] : msq[30:0];
                    sq_cnt_reg <= sq_cnt_reg + 1'b1;
                    if (sq_cnt_reg == 4'd15)
                    begin
                        state_reg <= S_LOG_ACC;
                    end
                end

                S_LOG_ACC:
                begin
                    case (log_sel_reg)
                        LOG_RATIO:
                        begin
                            l2_reg      <= l2_reg + log_val;
                            log_sel_reg <= LOG_NUM;
                            state_reg   <= S_LOG_NORM;
                        end
                        LOG_NUM:
                        begin
                            l2_reg      <= l2_reg + log_val;
                            log_sel_reg <= LOG_SUM;
                            state_reg   <= S_LOG_NORM;
                        end
                        default:
                        begin
                            l2_reg    <= l2_reg - log_val;
                            state_reg <= S_MUL;
                        end
                    endcase
                end

                S_MUL:
                begin
                    dprod_reg <= dprod_calc;
                    nprod_reg <= beta_reg * 15'(ntcs_pkg::T0_HUND);
                    state_reg <= S_DSUM;
                end

                S_DSUM:
                begin
                    if (d_sum <= 42'sd0)
                    begin
                        // no positive solution of the beta equation
                        raw_reg   <= -17'(ntcs_pkg::RAW_CLIP);
                        state_reg <= S_RESULT;
                    end
                    else
                    begin
                        d_reg     <= d_sum[40:0];
                        state_reg <= S_NCHK;
                    end
                end

                S_NCHK:
                begin
                    if (n_ovf)
                    begin
                        raw_reg   <= 17'(ntcs_pkg::RAW_CLIP);
                        state_reg <= S_RESULT;
                    end
                    else
                    begin
                        div_rem_reg <= {4'b0000, n_full[53:17]};
                        div_low_reg <= LOW_W'(n_full[16:0]) << (LOW_W - ntcs_pkg::BETA_Q_W);
                        div_q_reg   <= '0;
                        div_cnt_reg <= ITER_W'(ntcs_pkg::BETA_Q_W);
                        div_win_reg <= 1'b0;
                        state_reg   <= S_DIV;
                    end
                end

                S_DIV:
                begin
                    div_rem_reg <= rem_ge ? rem_diff[40:0] : rem_sh[40:0];
                    div_low_reg <= div_low_reg << 1;
                    div_q_reg   <= {div_q_reg[LOW_W-2:0], rem_ge};
                    div_cnt_reg <= div_cnt_reg - 1'b1;
                    if (div_cnt_reg == ITER_W'(1))
                    begin
                        state_reg <= div_win_reg ? S_WFIN : S_BFIN;
                    end
                end

                S_BFIN:
                begin
                    if (bfin_t > 19'(ntcs_pkg::RAW_CLIP))
                    begin
                        raw_reg <= 17'(ntcs_pkg::RAW_CLIP);
                    end
                    else
                    begin
                        raw_reg <= bfin_t[16:0];
                    end
                    state_reg <= S_RESULT;
                end

                S_RESULT:
                begin
                    if (fin_fault && fault_cnt_reg != 16'hFFFF)
                    begin
                        fault_cnt_reg <= fault_cnt_reg + 1'b1;
                    end
                    if (ch_reg)
                    begin
                        v2_reg    <= fin_v;
                        f2_reg    <= fin_fault;
                        state_reg <= S_WREAD;
                    end
                    else
                    begin
                        v1_reg    <= fin_v;
                        f1_reg    <= fin_fault;
                        ch_reg    <= 1'b1;
                        state_reg <= S_SETUP;
                    end
                end

                S_WREAD:
                begin
                    // old entry of the slot comes out of the ram next cycle
                    state_reg <= S_WUPD;
                end

                S_WUPD:
                begin
                    tot1_reg  <= tot1_n;
                    tot2_reg  <= tot2_n;
                    ch_reg    <= 1'b0;
                    state_reg <= S_WLOAD;
                end

                S_WLOAD:
                begin
                    neg_reg     <= win_a[TOT_W-1];
                    div_rem_reg <= '0;
                    div_low_reg <= LOW_W'(win_dvd) << (LOW_W - TOT_W);
                    div_q_reg   <= '0;
                    d_reg       <= 41'(win_cnt);
                    div_cnt_reg <= ITER_W'(TOT_W);
                    div_win_reg <= 1'b1;
                    state_reg   <= S_DIV;
                end

                S_WFIN:
                begin
                    if (ch_reg)
                    begin
                        sm2_reg   <= win_res[15:0];
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        sm1_reg   <= win_res[15:0];
                        ch_reg    <= 1'b1;
                        state_reg <= S_WLOAD;
                    end
                end

                S_OUT:
                begin
                    if (!out_valid_reg || out_ch.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_sm1_reg   <= sm1_reg;
                        out_sm2_reg   <= sm2_reg;
                        out_f1_reg    <= f1_reg;
                        out_f2_reg    <= f2_reg;
                        out_err_reg   <= fault_cnt_reg;
                        if (slot_reg == SLOT_LAST)
                        begin
                            slot_reg <= '0;
                            full_reg <= 1'b1;
                        end
                        else
                        begin
                            slot_reg <= slot_reg + 1'b1;
                        end
                        state_reg <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // samples are taken only between bursts
    assign in_ch.ready        = (state_reg == S_IDLE);

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.smooth_one  = out_sm1_reg;
    assign out_ch.smooth_two  = out_sm2_reg;
    assign out_ch.fault_one   = out_f1_reg;
    assign out_ch.fault_two   = out_f2_reg;
    assign out_ch.error_total = out_err_reg;

`ifndef NO_ASSERTIONS
    // write slot always inside the window
    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        slot_reg <= SLOT_LAST)
        else $error("window slot beyond window depth");

    // burst counter never reaches the burst length
    a_burst_range: assert property (@(posedge clk) disable iff (!rst_n)
        bcount_reg <= BC_LAST)
        else $error("burst counter overrun");

    // saturating fault counter never goes down
    a_fault_mono: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> fault_cnt_reg >= $past(fault_cnt_reg))
        else $error("fault counter decreased");

    // a result appears only from the output step of the sequencer
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result loaded outside output step");
`endif

endmodule

/* tb/sv/ntc_beta_temperature_smoother_top_test.sv */
// self-checking testbench of the two channel ntc beta temperature smoother
`timescale 1ns / 1ps

module ntc_beta_temperature_smoother_top_test;

    localparam int OVERSAMPLE  = 16;
    localparam int WINDOW      = 10;
    // settle time leaves a wide margin over one burst conversion
    localparam int SETTLE      = 400;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 1500;

    // one expected reading of both channels
    typedef struct {
        ntcs_pkg::temp_t smooth_one;
        ntcs_pkg::temp_t smooth_two;
        logic            fault_one;
        logic            fault_two;
        logic [15:0]     error_total;
    } reading_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [ntcs_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [ntcs_pkg::CFG_DATA_W-1:0] cfg_data;

    ntcs_in_if  in_ch ();
    ntcs_out_if out_ch ();

    ntc_beta_temperature_smoother_top #(
        .OVERSAMPLE(OVERSAMPLE),
        .WINDOW    (WINDOW)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .out_ch   (out_ch),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // predictor copy of the registers
    logic [15:0]        ratio_q;
    logic [13:0]        beta_q;
    logic [11:0]        adc_lo_q;
    logic [11:0]        adc_hi_q;
    logic signed [15:0] temp_lo_q;
    logic signed [15:0] temp_hi_q;
    logic signed [10:0] offset_one_q;
    logic signed [10:0] offset_two_q;

    // predictor copy of the block state
    int unsigned sum_one;
    int unsigned sum_two;
    int unsigned burst_items;
    int          win_one [WINDOW];
    int          win_two [WINDOW];
    int          total_one;
    int          total_two;
    int unsigned slot_q;
    bit          filled_q;
    int unsigned faults_q;

    reading_t pending_readings[$];

    int  mismatches;
    int  readings_seen;
    int  items_sent;
    int  fault_flags_seen;
    int  cycles;
    bit  quiet;       // no idling on either side
    bit  hold_req;    // asks the sink process for a long hold-off
    int  hold_left;
    int  ready_gap;

    // clock, 8 ns period
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d readings pending", cycles,
                     pending_readings.size());
            $display("status: fail");
            $finish;
        end
    end

    // base-2 log in q16: msb index then 16 squarings of the q30 mantissa
    function automatic longint log2_fix(int unsigned x);
        int unsigned e;
        int unsigned frac;
        longint unsigned m;
        e = 0;
        frac = 0;
        while (e < 30 && (x >> (e + 1)) != 0)
            e++;
        m = longint'(x) << (30 - e);
        for (int i = 0; i < 16; i++)
        begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd1 << 31))
            begin
                m = m >> 1;
                frac = frac | 1;
            end
        end
        return (longint'(e) << 16) | longint'(frac);
    endfunction

    // burst sum to raw temperature in hundredths, with the fault decision
    function automatic int burst_to_temp(int unsigned s, output bit flt);
        int unsigned full;
        int unsigned num;
        bit          sat;
        longint      raw;
        longint      l2;
        longint      d;
        longint      n;
        full = ntcs_pkg::ADC_FULL * OVERSAMPLE;
        sat = (s <= adc_lo_q * OVERSAMPLE) || (s >= adc_hi_q * OVERSAMPLE);
        // zero sum is taken as a mean of one for the resistance
        if (s == 0)
            s = OVERSAMPLE;
        num = (s >= full) ? 0 : full - s;
        if (num == 0 || ratio_q == 0)
            raw = -ntcs_pkg::KELVIN_HUND;        // zero resistance reads as 0 K
        else
        begin
            l2 = log2_fix(ratio_q) - (longint'(ntcs_pkg::RATIO_FRAC) << 16)
                 + log2_fix(num) - log2_fix(s);
            d = longint'(beta_q) * 64'd16777216 + l2 * ntcs_pkg::LN2_SCALED;
            if (d <= 0)
                raw = -ntcs_pkg::RAW_CLIP;       // no positive solution
            else
            begin
                n = longint'(beta_q) * ntcs_pkg::T0_HUND * 64'd16777216;
                raw = (n + d / 2) / d - ntcs_pkg::KELVIN_HUND;
                if (raw > ntcs_pkg::RAW_CLIP)
                    raw = ntcs_pkg::RAW_CLIP;
                if (raw < -ntcs_pkg::RAW_CLIP)
                    raw = -ntcs_pkg::RAW_CLIP;
            end
        end
        flt = sat || raw < temp_lo_q || raw > temp_hi_q;
        return int'(raw);
    endfunction

    function automatic int clamp_offset(int raw, int off);
        if (raw < ntcs_pkg::TEMP_MIN)
            raw = ntcs_pkg::TEMP_MIN;
        if (raw > ntcs_pkg::TEMP_MAX)
            raw = ntcs_pkg::TEMP_MAX;
        return raw + off;
    endfunction

    // rounded mean, halves away from zero
    function automatic int mean_round(int a, int n);
        if (a >= 0)
            return (a + n / 2) / n;
        return -((-a + n / 2) / n);
    endfunction

    // fold one accepted sample pair into the predictor
    task automatic predict_reading(ntcs_pkg::sample_t s1, ntcs_pkg::sample_t s2);
        bit       f1;
        bit       f2;
        int       v1;
        int       v2;
        int       cnt;
        reading_t r;
        sum_one += s1;
        sum_two += s2;
        burst_items++;
        if (burst_items < OVERSAMPLE)
            return;
        v1 = clamp_offset(burst_to_temp(sum_one, f1), offset_one_q);
        v2 = clamp_offset(burst_to_temp(sum_two, f2), offset_two_q);
        if (f1 && faults_q < 65535)
            faults_q++;
        if (f2 && faults_q < 65535)
            faults_q++;
        sum_one = 0;
        sum_two = 0;
        burst_items = 0;
        if (filled_q)
        begin
            total_one -= win_one[slot_q];
            total_two -= win_two[slot_q];
        end
        win_one[slot_q] = v1;
        win_two[slot_q] = v2;
        total_one += v1;
        total_two += v2;
        cnt = filled_q ? WINDOW : slot_q + 1;
        r.smooth_one  = ntcs_pkg::temp_t'(mean_round(total_one, cnt));
        r.smooth_two  = ntcs_pkg::temp_t'(mean_round(total_two, cnt));
        r.fault_one   = f1;
        r.fault_two   = f2;
        r.error_total = faults_q[15:0];
        pending_readings.push_back(r);
        slot_q++;
        if (slot_q >= WINDOW)
        begin
            slot_q = 0;
            filled_q = 1'b1;
        end
    endtask

    // sink side: random ready bursts, long hold-off on request
    always @(posedge clk)
    begin
        if (hold_req)
        begin
            hold_req  <= 1'b0;
            hold_left <= HOLD_CYCLES;
            out_ch.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ch.ready <= 1'b0;
        end
        else if (quiet)
            out_ch.ready <= 1'b1;
        else if (ready_gap > 0)
        begin
            ready_gap <= ready_gap - 1;
            out_ch.ready <= 1'b0;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            ready_gap <= $urandom_range(1, 16) - 1;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= 1'b1;
    end

    // checks every result transfer against the oldest expectation
    always @(posedge clk)
    begin
        reading_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            readings_seen++;
            if (out_ch.fault_one === 1'b1 || out_ch.fault_two === 1'b1)
                fault_flags_seen++;
            if (pending_readings.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected reading at cycle %0d", cycles);
            end
            else
            begin
                want = pending_readings.pop_front();
                if (out_ch.smooth_one !== want.smooth_one
                    || out_ch.smooth_two !== want.smooth_two
                    || out_ch.fault_one !== want.fault_one
                    || out_ch.fault_two !== want.fault_two
                    || out_ch.error_total !== want.error_total)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("reading %0d: expected %0d %0d %b %b %0d, got %0d %0d %b %b %0d",
                                 readings_seen, want.smooth_one, want.smooth_two,
                                 want.fault_one, want.fault_two, want.error_total,
                                 out_ch.smooth_one, out_ch.smooth_two, out_ch.fault_one,
                                 out_ch.fault_two, out_ch.error_total);
                end
            end
        end
    end

    // one sample pair transfer; valid stays high for a following item unless a sender gap drops it
    task automatic send_pair(ntcs_pkg::sample_t s1, ntcs_pkg::sample_t s2);
        in_ch.valid      <= 1'b1;
        in_ch.sample_one <= s1;
        in_ch.sample_two <= s2;
        do
            @(posedge clk);
        while (!in_ch.ready);
        predict_reading(s1, s2);
        items_sent++;
        // random sender gap
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16))
                @(posedge clk);
        end
    endtask

    // a burst around one level, with optional spread
    task automatic send_burst(ntcs_pkg::sample_t lvl1, ntcs_pkg::sample_t lvl2, int spread);
        int a;
        int b;
        for (int i = 0; i < OVERSAMPLE; i++)
        begin
            a = int'(lvl1) + $urandom_range(0, 2 * spread) - spread;
            b = int'(lvl2) + $urandom_range(0, 2 * spread) - spread;
            a = (a < 0) ? 0 : (a > ntcs_pkg::ADC_FULL) ? ntcs_pkg::ADC_FULL : a;
            b = (b < 0) ? 0 : (b > ntcs_pkg::ADC_FULL) ? ntcs_pkg::ADC_FULL : b;
            send_pair(ntcs_pkg::sample_t'(a), ntcs_pkg::sample_t'(b));
        end
    endtask

    // stop offering and wait until the block has delivered everything
    task automatic drain_readings();
        in_ch.valid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (SETTLE)
            @(posedge clk);
    endtask

    task automatic write_reg(ntcs_pkg::cfg_reg_t idx, logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        case (idx)
            ntcs_pkg::REG_DIVIDER_RATIO:   ratio_q      = value;
            ntcs_pkg::REG_BETA_VALUE:      beta_q       = value[13:0];
            ntcs_pkg::REG_ADC_LOW_LIMIT:   adc_lo_q     = value[11:0];
            ntcs_pkg::REG_ADC_HIGH_LIMIT:  adc_hi_q     = value[11:0];
            ntcs_pkg::REG_TEMP_LOW_LIMIT:  temp_lo_q    = value;
            ntcs_pkg::REG_TEMP_HIGH_LIMIT: temp_hi_q    = value;
            ntcs_pkg::REG_OFFSET_ONE:      offset_one_q = value[10:0];
            ntcs_pkg::REG_OFFSET_TWO:      offset_two_q = value[10:0];
            default: ;
        endcase
    endtask

    // writes every register; block must be idle
    task automatic load_setup(int ratio, int beta, int alo, int ahi, int tlo, int thi,
                              int off1, int off2);
        write_reg(ntcs_pkg::REG_DIVIDER_RATIO, ratio[15:0]);
        write_reg(ntcs_pkg::REG_BETA_VALUE, beta[15:0]);
        write_reg(ntcs_pkg::REG_ADC_LOW_LIMIT, alo[15:0]);
        write_reg(ntcs_pkg::REG_ADC_HIGH_LIMIT, ahi[15:0]);
        write_reg(ntcs_pkg::REG_TEMP_LOW_LIMIT, tlo[15:0]);
        write_reg(ntcs_pkg::REG_TEMP_HIGH_LIMIT, thi[15:0]);
        write_reg(ntcs_pkg::REG_OFFSET_ONE, off1[15:0]);
        write_reg(ntcs_pkg::REG_OFFSET_TWO, off2[15:0]);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // reset values, zero sum, full scale and the window fill
    task automatic test_defaults();
        send_burst(12'd0, 12'd4095, 0);
        send_burst(12'd4095, 12'd0, 0);
        send_burst(12'd2048, 12'd1, 0);
        send_burst(12'd1234, 12'd3000, 0);
    endtask

    // zero divider ratio, negative denominator and register extremes
    task automatic test_corner_setups();
        drain_readings();
        load_setup(0, 3950, 10, 4085, -1000, 10000, 1000, -1000);
        send_burst(12'd2048, 12'd100, 8);
        drain_readings();
        load_setup(1, 1000, 0, 4095, -10000, 20000, -1000, 1000);
        send_burst(12'd4094, 12'd4000, 0);
        send_burst(12'd3, 12'd2000, 2);
        drain_readings();
        load_setup(65535, 10000, 4095, 0, 20000, -10000, 0, 0);
        send_burst(12'd50, 12'd4000, 40);
        drain_readings();
        load_setup(65535, 1000, 0, 4095, -10000, 20000, 1000, 1000);
        send_burst(12'd20, 12'd4080, 10);
        send_burst(12'd3500, 12'd600, 10);
    endtask

    // random settings, mostly clean bursts, some noisy ones
    task automatic test_random_setups();
        int lo;
        int hi;
        for (int p = 0; p < 6; p++)
        begin
            drain_readings();
            lo = $urandom_range(0, 30000) - 10000;
            hi = $urandom_range(0, 30000) - 10000;
            if (lo > hi && $urandom_range(0, 3) != 0)
            begin
                lo = lo ^ hi;
                hi = lo ^ hi;
                lo = lo ^ hi;
            end
            load_setup($urandom_range(1, 65535), $urandom_range(1000, 10000),
                       $urandom_range(0, 200), $urandom_range(3900, 4095), lo, hi,
                       $urandom_range(0, 2000) - 1000, $urandom_range(0, 2000) - 1000);
            for (int b = 0; b < 14; b++)
            begin
                if ($urandom_range(0, 4) == 0)
                    send_burst(ntcs_pkg::sample_t'($urandom),
                               ntcs_pkg::sample_t'($urandom), 2048);
                else
                    send_burst(ntcs_pkg::sample_t'($urandom),
                               ntcs_pkg::sample_t'($urandom), $urandom_range(0, 64));
            end
        end
    endtask

    // sink holds off while the source keeps offering, then a full drain
    task automatic test_backpressure();
        drain_readings();
        load_setup(4096, 3950, 10, 4085, -1000, 10000, 0, 0);
        hold_req = 1'b1;
        for (int b = 0; b < 3; b++)
            send_burst(ntcs_pkg::sample_t'($urandom), ntcs_pkg::sample_t'($urandom), 16);
        drain_readings();
    endtask

    // last stretch with no idling at all
    task automatic test_full_rate();
        quiet = 1'b1;
        for (int b = 0; b < 4; b++)
            send_burst(ntcs_pkg::sample_t'($urandom), ntcs_pkg::sample_t'($urandom), 32);
        in_ch.valid <= 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.sample_one = '0;
        in_ch.sample_two = '0;
        out_ch.ready = 1'b0;
        quiet = 1'b0;
        hold_req = 1'b0;
        hold_left = 0;
        ready_gap = 0;
        cycles = 0;
        mismatches = 0;
        readings_seen = 0;
        items_sent = 0;
        fault_flags_seen = 0;
        // predictor reset state
        ratio_q = 16'd4096;
        beta_q = 14'd3950;
        adc_lo_q = 12'd10;
        adc_hi_q = 12'd4085;
        temp_lo_q = -16'sd1000;
        temp_hi_q = 16'sd10000;
        offset_one_q = '0;
        offset_two_q = '0;
        sum_one = 0;
        sum_two = 0;
        burst_items = 0;
        total_one = 0;
        total_two = 0;
        slot_q = 0;
        filled_q = 1'b0;
        faults_q = 0;
        for (int i = 0; i < WINDOW; i++)
        begin
            win_one[i] = 0;
            win_two[i] = 0;
        end
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_defaults();
        test_corner_setups();
        test_random_setups();
        test_backpressure();
        test_full_rate();

        // wait out the tail, bounded by the cycle limit
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (SETTLE)
            @(posedge clk);

        $display("%0d sample pairs sent, %0d readings checked, %0d with a fault flag",
                 items_sent, readings_seen, fault_flags_seen);
        if (mismatches == 0 && pending_readings.size() == 0)
            $display("status: pass");
        else
        begin
            $display("%0d mismatches, %0d readings missing", mismatches,
                     pending_readings.size());
            $display("status: fail");
        end
        $finish;
    end

endmodule
